>>> rtl/srmp_pkg.sv
// ----------------------------------------------------------------------------
// srmp_pkg: shared types and constants for the step response predictor
// Operation codes, register map, Q16.16 limits and controller/datapath structs.
// ----------------------------------------------------------------------------
package srmp_pkg;

    localparam int DATA_W = 32;

    // operation codes of an input request
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // register select (paddr[2])
    localparam logic REG_MODEL_LENGTH  = 1'b0;
    localparam logic REG_INITIAL_INPUT = 1'b1;

    localparam logic [6:0] DEFAULT_MODEL_LENGTH = 7'd60;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // controller -> datapath
    typedef struct packed {
        logic take_load;    // write coefficient from the input request
        logic take_start;   // previous input <= initial input
        logic take_sample;  // capture delta, previous input <= plant input
        logic clear_wr;     // write zero to history entry at index
        logic run_issue;    // read history/coefficient for entry at index
        logic run_last;     // entry at index is the last one in use
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pipe_busy;    // multiply-add stages still hold an entry
        logic out_full;     // result register holds an untaken result
    } t_dp_stat;

endpackage

>>> rtl/step_response_model_predictor.sv
// ----------------------------------------------------------------------------
// step_response_model_predictor: DMC-style plant output prediction
// Top level: register port, sequencer and multiply-add datapath.
// ----------------------------------------------------------------------------
// Predicts the plant output from a loaded step response, Q16.16 throughout.
// One request is handled at a time. A load request writes its coefficient and
// leaves the block idle. A start request zeroes the history memory one entry
// per cycle. A sample request sweeps the n entries in use (model_length,
// capped at MAX_HORIZON) before the next request can be taken: it is accepted,
// checks the output register, then issues one history/coefficient read and
// one 32x32 multiply-add per entry through a three-stage pipe, and drains the
// pipe. A sample does not begin its sweep while the previous result is still
// waiting in the output register. After reset the block clears every history
// entry and holds o_in_stall high meanwhile; register writes are taken at any
// time. model_output is registered as history entry zero is written back,
// as the first entry of the sweep leaves the pipe.
// ----------------------------------------------------------------------------
module step_response_model_predictor
    import srmp_pkg::*;
#(
    parameter int MAX_HORIZON = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic [5:0]               i_coeff_index,
    input  logic signed [DATA_W-1:0] i_coeff_value,
    input  logic signed [DATA_W-1:0] i_plant_input,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_model_output
);

    localparam int IDX_W = $clog2(MAX_HORIZON);

    logic [6:0]               r_model_length;
    logic signed [DATA_W-1:0] r_initial_input;
    logic                     reg_wr;
    logic                     req_take;

    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic [IDX_W-1:0]         idx;

    // register port: always ready, decode on paddr[2]
    assign pready = 1'b1;
    assign reg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_length  <= DEFAULT_MODEL_LENGTH;
            r_initial_input <= '0;
        end else if (reg_wr) begin
            case (paddr[2])
                REG_MODEL_LENGTH:  r_model_length  <= pwdata[6:0];
                REG_INITIAL_INPUT: r_initial_input <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // unaligned reads return zero
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (paddr[2])
                REG_MODEL_LENGTH:  prdata = {25'd0, r_model_length};
                REG_INITIAL_INPUT: prdata = r_initial_input;
                default:           prdata = '0;
            endcase
        end
    end

    // the sequencer acts on a request only while it is idle; valid is passed ungated
    assign req_take = i_in_valid;

    srmp_ctrl #(
        .MAX_HORIZON (MAX_HORIZON)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (req_take),
        .i_operation    (i_operation),
        .i_model_length (r_model_length),
        .i_stat         (stat),
        .o_in_stall     (o_in_stall),
        .o_cmd          (cmd),
        .o_idx          (idx)
    );

    srmp_datapath #(
        .MAX_HORIZON (MAX_HORIZON)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .i_coeff_index   (i_coeff_index),
        .i_coeff_value   (i_coeff_value),
        .i_plant_input   (i_plant_input),
        .i_initial_input (r_initial_input),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_model_output  (o_model_output),
        .o_stat          (stat)
    );

endmodule

>>> rtl/srmp_ctrl.sv
// ----------------------------------------------------------------------------
// srmp_ctrl: sequencer for the step response predictor
// Walks the history for clearing passes and per-sample multiply-add sweeps.
// ----------------------------------------------------------------------------
module srmp_ctrl
    import srmp_pkg::*;
#(
    parameter int MAX_HORIZON = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [1:0]                     i_operation,
    input  logic [6:0]                     i_model_length,
    input  t_dp_stat                       i_stat,
    output logic                           o_in_stall,
    output t_dp_cmd                        o_cmd,
    output logic [$clog2(MAX_HORIZON)-1:0] o_idx
);

    localparam int IDX_W = $clog2(MAX_HORIZON);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_HORIZON - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [31:0]      HMAX     = 32'(MAX_HORIZON);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;
    logic [31:0]      len_eff;

    // entries in use, limited to the history depth
    assign len_eff = (32'(i_model_length) > HMAX) ? HMAX : 32'(i_model_length);

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_idx      = r_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_last_idx = r_last_idx;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        OP_LOAD: begin
                            o_cmd.take_load = 1'b1;
                        end
                        OP_START: begin
                            o_cmd.take_start = 1'b1;
                            n_state          = ST_CLEAR;
                            n_cnt            = '0;
                        end
                        OP_SAMPLE: begin
                            // zero length: sample is dropped, no state change
                            if (i_model_length != 7'd0) begin
                                o_cmd.take_sample = 1'b1;
                                n_last_idx        = IDX_W'(len_eff - 32'd1);
                                n_state           = ST_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (r_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + IDX_ONE;
                end
            end
            ST_WAIT: begin
                if (!i_stat.out_full) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                o_cmd.run_issue = 1'b1;
                o_cmd.run_last  = (r_cnt == r_last_idx);
                if (r_cnt == r_last_idx) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + IDX_ONE;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_last_idx <= n_last_idx;
        end
    end

endmodule

>>> rtl/srmp_datapath.sv
// ----------------------------------------------------------------------------
// srmp_datapath: history and coefficient memories with a multiply-add pipe
// Read, multiply, add-and-saturate, write back; one history entry per cycle.
// ----------------------------------------------------------------------------
module srmp_datapath
    import srmp_pkg::*;
#(
    parameter int MAX_HORIZON = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    input  logic [$clog2(MAX_HORIZON)-1:0] i_idx,
    input  logic [5:0]                     i_coeff_index,
    input  logic signed [DATA_W-1:0]       i_coeff_value,
    input  logic signed [DATA_W-1:0]       i_plant_input,
    input  logic signed [DATA_W-1:0]       i_initial_input,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic signed [DATA_W-1:0]       o_model_output,
    output t_dp_stat                       o_stat
);

    localparam int IDX_W = $clog2(MAX_HORIZON);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
    localparam logic [31:0]      HMAX    = 32'(MAX_HORIZON);

    logic signed [DATA_W-1:0] r_hist_mem [MAX_HORIZON];
    logic signed [DATA_W-1:0] r_coef_mem [MAX_HORIZON];

    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_delta;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W-1:0] delta_sat;

    // stage 1: memory read data
    logic                     r_v1;
    logic [IDX_W-1:0]         r_idx1;
    logic signed [DATA_W-1:0] r_hist_q;
    logic signed [DATA_W-1:0] r_coef_q;
    // stage 2: product, already shifted (floor)
    logic                     r_v2;
    logic [IDX_W-1:0]         r_idx2;
    logic signed [DATA_W-1:0] r_h2;
    logic signed [47:0]       r_prod;
    logic signed [63:0]       prod_full;
    // stage 3: add, saturate, write back
    logic signed [48:0]       sum;
    logic signed [DATA_W-1:0] sum_sat;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;

    logic [IDX_W-1:0]         rd_addr;
    logic                     hist_we;
    logic [IDX_W-1:0]         hist_wa;
    logic signed [DATA_W-1:0] hist_wd;
    logic                     coef_we;

    // input change, saturated
    assign diff      = {i_plant_input[DATA_W-1], i_plant_input} - {r_prev[DATA_W-1], r_prev};
    assign delta_sat = (diff[DATA_W] != diff[DATA_W-1]) ?
                       (diff[DATA_W] ? Q_MIN : Q_MAX) : diff[DATA_W-1:0];

    // entry i takes old entry i+1; the last entry in use keeps itself
    assign rd_addr = i_cmd.run_last ? i_idx : (i_idx + IDX_ONE);

    assign prod_full = r_delta * r_coef_q;

    assign sum     = 49'(r_prod) + 49'(r_h2);
    assign sum_sat = (sum[48:31] == {18{sum[48]}}) ? sum[DATA_W-1:0] :
                     (sum[48] ? Q_MIN : Q_MAX);

    assign hist_we = i_cmd.clear_wr | r_v2;
    assign hist_wa = i_cmd.clear_wr ? i_idx : r_idx2;
    assign hist_wd = i_cmd.clear_wr ? '0 : sum_sat;

    assign coef_we = i_cmd.take_load & (32'(i_coeff_index) < HMAX);

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_wa] <= hist_wd;
        end
        if (i_cmd.run_issue) begin
            r_hist_q <= r_hist_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[IDX_W'(i_coeff_index)] <= i_coeff_value;
        end
        if (i_cmd.run_issue) begin
            r_coef_q <= r_coef_mem[i_idx];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_h2   <= r_hist_q;
        r_prod <= prod_full[63:16];
        if (i_cmd.take_sample) begin
            r_delta <= delta_sat;
        end
        if (r_v2 && (r_idx2 == '0)) begin
            r_out_data <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.run_issue;
            r_v2 <= r_v1;
            if (i_cmd.take_start) begin
                r_prev <= i_initial_input;
            end else if (i_cmd.take_sample) begin
                r_prev <= i_plant_input;
            end
            if (r_v2 && (r_idx2 == '0)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_model_output   = r_out_data;
    assign o_stat.pipe_busy = r_v1 | r_v2;
    assign o_stat.out_full  = r_out_valid;

endmodule

>>> rtl/srmp_checker.sv
// ----------------------------------------------------------------------------
// srmp_checker: port-level checks for the step response predictor
// Result channel holding, reset behavior and request/result sequencing.
// ----------------------------------------------------------------------------
module srmp_checker
    import srmp_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [1:0]               i_operation,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_model_output
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_model_output))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("requests taken during post-reset clearing");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == OP_START) |=> o_in_stall)
        else $error("start request did not begin a clearing pass");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("result appeared outside a sample sweep");

endmodule

bind step_response_model_predictor srmp_checker u_srmp_checker (.*);

>>> tb/tb_step_response_model_predictor.sv
// ----------------------------------------------------------------------------
// tb_step_response_model_predictor: self-checking bench for the DMC predictor
// Loads step-response coefficients, restarts and samples the block under a
// series of model lengths and initial inputs. Every sample response is checked
// in order against an in-bench Q16.16 prediction of the history update or a typed value.
// ----------------------------------------------------------------------------
module tb_step_response_model_predictor;
    import srmp_pkg::*;

    localparam int HORIZON         = 64;
    localparam int TOTAL_ITEMS     = 1700;
    localparam int PHASES          = 18;
    localparam int PHASE_ITEMS     = TOTAL_ITEMS / PHASES;
    localparam int DIRECTED_ROWS   = 18;
    // a start sweeps the whole history, a sample drains well after its result
    localparam int SETTLE_CYCLES   = 2 * HORIZON + 20;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 10;

    // code 3 is not defined by the block; it must be dropped silently
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         idx;
        logic signed [31:0] coeff;
        logic signed [31:0] pin;
        logic               has_typed;   // typed_out overrides the prediction
        logic signed [31:0] typed_out;
    } t_request;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [1:0]         in_operation = OP_LOAD;
    logic [5:0]         in_coeff_idx = '0;
    logic signed [31:0] in_coeff_val = '0;
    logic signed [31:0] in_plant_in  = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [31:0] out_model;

    step_response_model_predictor #(.MAX_HORIZON(HORIZON)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (in_operation),
        .i_coeff_index  (in_coeff_idx),
        .i_coeff_value  (in_coeff_val),
        .i_plant_input  (in_plant_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_model_output (out_model)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction state: mirrors the block after reset
    // ------------------------------------------------------------------------
    logic signed [31:0] hist_q16  [HORIZON] = '{default: '0};
    logic signed [31:0] coeff_q16 [HORIZON] = '{default: '0};
    logic signed [31:0] prev_input          = '0;
    logic [6:0]         cfg_model_length    = DEFAULT_MODEL_LENGTH;
    logic signed [31:0] cfg_initial_input   = '0;

    logic signed [31:0] expected_outputs [$];
    logic signed [31:0] oldest_output;

    // pacing, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches   = 0;
    int quiet_cycles = 0;
    int n_loads      = 0;
    int n_starts     = 0;
    int n_samples    = 0;
    int n_outputs    = 0;
    int n_reg_writes = 0;

    function automatic logic signed [31:0] sat_q16(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    // History update of one request; produced is set only for a sample
    // with a nonzero model length.
    function automatic void predict_model_output(input t_request r, output bit produced,
                                                 output logic signed [31:0] y);
        int     n;
        longint delta;
        longint prod;
        produced = 1'b0;
        y        = '0;
        case (r.op)
            // the 6-bit index cannot exceed the 64-entry horizon
            OP_LOAD: coeff_q16[r.idx] = r.coeff;
            OP_START: begin
                foreach (hist_q16[i]) hist_q16[i] = '0;
                prev_input = cfg_initial_input;
            end
            OP_SAMPLE: begin
                n = (cfg_model_length > HORIZON) ? HORIZON : int'(cfg_model_length);
                if (n != 0) begin
                    // shift toward the front, last entry in use keeps its value
                    for (int i = 0; i + 1 < n; i++) hist_q16[i] = hist_q16[i + 1];
                    delta = sat_q16(longint'(r.pin) - longint'(prev_input));
                    for (int i = 0; i < n; i++) begin
                        // exact Q32.32 product, floor back to Q16.16
                        prod        = (delta * longint'(coeff_q16[i])) >>> 16;
                        hist_q16[i] = sat_q16(longint'(hist_q16[i]) + prod);
                    end
                    prev_input = r.pin;
                    produced   = 1'b1;
                    y          = hist_q16[0];
                end
            end
            default: ;
        endcase
    endfunction

    // Random request of a given kind. Coefficients stay mostly within +-2.0 and
    // inputs half the time step near the last input, so sums do not all pin at the rails.
    function automatic t_request random_request(input logic [1:0] op);
        t_request r;
        int       pick;
        r.op        = op;
        r.idx       = 6'($urandom);
        r.has_typed = 1'b0;
        r.typed_out = '0;
        pick = $urandom_range(99);
        if (pick < 75)      r.coeff = $signed($urandom) >>> 14;
        else if (pick < 88) r.coeff = 32'($urandom);
        else begin
            case ($urandom_range(3))
                0:       r.coeff = Q_MAX;
                1:       r.coeff = Q_MIN;
                2:       r.coeff = 32'sh0001_0000;
                default: r.coeff = '0;
            endcase
        end
        pick = $urandom_range(99);
        if (pick < 50)      r.pin = prev_input + ($signed($urandom) >>> 13);
        else if (pick < 70) r.pin = $signed($urandom) >>> 12;
        else if (pick < 85) begin
            case ($urandom_range(2))
                0:       r.pin = Q_MAX;
                1:       r.pin = Q_MIN;
                default: r.pin = '0;
            endcase
        end else            r.pin = 32'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Register port: setup cycle, then access until pready
    // ------------------------------------------------------------------------
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (reg_sel == REG_MODEL_LENGTH) cfg_model_length  = value[6:0];
        else                             cfg_initial_input = value;
        n_reg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Request side. Valid stays high across back-to-back requests; it is
    // only lowered for an idle gap, a hold until all outputs are back, or a drain.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_request r, input bit may_hold);
        int                 gap;
        bit                 produced;
        logic signed [31:0] y;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (may_hold && $urandom_range(99) < 2) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (expected_outputs.size() != 0);
        end else if (gap != 0) begin
            in_valid <= 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid     <= 1'b1;
        in_operation <= r.op;
        in_coeff_idx <= r.idx;
        in_coeff_val <= r.coeff;
        in_plant_in  <= r.pin;
        do @(posedge clk); while (in_stall);
        predict_model_output(r, produced, y);
        if (produced) expected_outputs.push_back(r.has_typed ? r.typed_out : y);
        case (r.op)
            OP_LOAD:   n_loads++;
            OP_START:  n_starts++;
            OP_SAMPLE: n_samples++;
            default: ;
        endcase
    endtask

    // Block is idle once every output is back and the trailing sweep is over.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, in-order compare against the oldest output
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            n_outputs++;
            if (expected_outputs.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: model_output %h with no sample outstanding",
                             $realtime, out_model);
                mismatches++;
            end else begin
                oldest_output = expected_outputs.pop_front();
                if (out_model !== oldest_output) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: model_output expected %h got %h",
                                 $realtime, oldest_output, out_model);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any accepted request or result restarts the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_request directed_rows [DIRECTED_ROWS];

    initial begin
        t_request   r;
        int         phase_items;
        int         run;
        int         pick;
        logic [6:0] len;

        // Directed rows run at model length 1 with coefficient 0 = 1.0, so
        // most outputs read straight off the inputs.
        directed_rows = '{
            '{OP_LOAD,   6'd0,  32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0},
            // sample before any start: reset history and previous input
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h0002_0000, 1'b1, 32'h0002_0000},
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
            // input change saturates at the negative rail
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF},
            '{OP_START,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
            // history cleared by the start
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{OP_LOAD,   6'd63, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{OP_LOAD,   6'd1,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
            '{OP_UNUSED, 6'h2A, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 32'h0},
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'hFFFF_0000, 1'b1, 32'hFFFF_0000},
            '{OP_LOAD,   6'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
            // huge negative product: sum saturates
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
            // smallest negative coefficient: floor rounding of the product
            '{OP_LOAD,   6'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
            '{OP_START,  6'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
            '{OP_SAMPLE, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{OP_LOAD,   6'd0,  32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 36;
        recv_stall_pct = 61;
        write_register(REG_MODEL_LENGTH, 32'd1);
        foreach (directed_rows[i]) send_request(directed_rows[i], 1'b0);
        drain_and_settle();

        // zero model length: samples are dropped without a result
        write_register(REG_MODEL_LENGTH, 32'd0);
        repeat (4) send_request(random_request(OP_SAMPLE), 1'b0);
        drain_and_settle();

        // Random phases: each sets a length and initial input, then runs
        // restart/sample sequences with some loads, restarts and junk mixed in.
        for (int p = 0; p < PHASES; p++) begin
            case (p * 3 / PHASES)
                0: begin send_idle_pct = 36; recv_stall_pct = 61; end
                1: begin send_idle_pct = 61; recv_stall_pct = 36; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            case (p % 6)
                0:       len = 7'd1;
                1:       len = 7'd64;
                2:       len = 7'd127;     // above the horizon, capped
                3:       len = 7'($urandom_range(3, 63));
                4:       len = 7'd2;
                default: len = 7'($urandom_range(65, 127));
            endcase
            write_register(REG_MODEL_LENGTH, {25'd0, len});
            case (p % 4)
                0:       write_register(REG_INITIAL_INPUT, '0);
                1:       write_register(REG_INITIAL_INPUT, Q_MAX);
                2:       write_register(REG_INITIAL_INPUT, Q_MIN);
                default: write_register(REG_INITIAL_INPUT, $urandom);
            endcase

            phase_items = 0;
            // fill the whole coefficient table before any long sweep
            if (p == 0) begin
                for (int c = 0; c < HORIZON; c++) begin
                    r     = random_request(OP_LOAD);
                    r.idx = 6'(c);
                    send_request(r, 1'b1);
                    phase_items++;
                end
            end
            while (phase_items < PHASE_ITEMS) begin
                send_request(random_request(OP_START), 1'b1);
                phase_items++;
                run = $urandom_range(4, 40);
                for (int k = 0; k < run && phase_items < PHASE_ITEMS; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 6)       send_request(random_request(OP_UNUSED), 1'b1);
                    else if (pick < 14) send_request(random_request(OP_LOAD), 1'b1);
                    else if (pick < 16) send_request(random_request(OP_START), 1'b1);
                    else                send_request(random_request(OP_SAMPLE), 1'b1);
                    phase_items++;
                end
            end
            drain_and_settle();
        end

        $display("Run covered %0d loads, %0d restarts and %0d samples; %0d outputs compared",
                 n_loads, n_starts, n_samples, n_outputs);
        $display("over %0d register writes: lengths 0, 1, 2, 64, capped and random, rail inputs",
                 n_reg_writes);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/srmp_pkg.sv
rtl/srmp_ctrl.sv
rtl/srmp_datapath.sv
rtl/step_response_model_predictor.sv
rtl/srmp_checker.sv
tb/tb_step_response_model_predictor.sv
